// File: rtl/core/mwqf_pkg.sv
// ----------------------------------------------------------------------------
// mwqf_pkg
// Shared types, constants and crc helpers for the weight query framer
// ----------------------------------------------------------------------------
package mwqf_pkg;

   localparam logic       KIND_REQUEST    = 1'b0;
   localparam logic       KIND_RX_BYTE    = 1'b1;
   localparam logic       RESULT_TX       = 1'b0;
   localparam logic       RESULT_WEIGHT   = 1'b1;

   localparam logic [7:0]  FUNC_READ_HOLD  = 8'h03;
   localparam logic [7:0]  REG_COUNT_LO    = 8'h02;
   localparam logic [7:0]  ZERO_BYTE       = 8'h00;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;

   localparam int          TX_IDX_W        = 3;
   localparam logic [2:0]  TX_IDX_ADDR     = 3'd0;
   localparam logic [2:0]  TX_IDX_FUNC     = 3'd1;
   localparam logic [2:0]  TX_IDX_COUNT_LO = 3'd5;
   localparam logic [2:0]  TX_IDX_CRC_LO   = 3'd6;
   localparam logic [2:0]  TX_IDX_CRC_HI   = 3'd7;

   localparam logic [3:0]  RX_SAT          = 4'd10;
   localparam logic [3:0]  FRAME_LEN       = 4'd9;
   localparam logic [3:0]  WEIGHT_FIRST    = 4'd3;
   localparam logic [3:0]  WEIGHT_LAST     = 4'd6;
   localparam logic signed [31:0] WEIGHT_ERROR = -32'sd1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_beat_type;

   typedef struct packed {
      logic              result_kind;
      logic [7:0]        tx_byte;
      logic              last;
      logic signed [31:0] weight;
      logic              error;
   } rsp_beat_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] tx_byte;
      logic       last;
   } tx_out_type;

   typedef struct packed {
      logic              emit;
      logic signed [31:0] weight;
      logic              error;
   } rx_out_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // full request crc, elaboration use only
   function automatic logic [15:0] frame_crc(input logic [7:0] addr);
      logic [15:0] c;
      c = crc_byte(CRC_INIT, addr);
      c = crc_byte(c, FUNC_READ_HOLD);
      c = crc_byte(c, ZERO_BYTE);
      c = crc_byte(c, ZERO_BYTE);
      c = crc_byte(c, ZERO_BYTE);
      c = crc_byte(c, REG_COUNT_LO);
      return c;
   endfunction

   function automatic logic [7:0][15:0] build_crc_cols();
      logic [7:0][15:0] cols;
      for (int i = 0; i < 8; i++) begin
         cols[i] = frame_crc(8'(1 << i)) ^ frame_crc(8'h00);
      end
      return cols;
   endfunction

   // crc is affine in the address byte
   localparam logic [15:0]      CRC_ZERO_ADDR = frame_crc(8'h00);
   localparam logic [7:0][15:0] CRC_COLS      = build_crc_cols();

   function automatic logic [15:0] crc_of_addr(input logic [7:0] addr);
      logic [15:0] c;
      c = CRC_ZERO_ADDR;
      for (int i = 0; i < 8; i++) begin
         if (addr[i]) begin
            c = c ^ CRC_COLS[i];
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/mwqf_tx.sv
// ----------------------------------------------------------------------------
// mwqf_tx
// Request frame sequencer: emits the eight request bytes, one per free slot
// ----------------------------------------------------------------------------
module mwqf_tx
   import mwqf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       out_free,
   input  logic [7:0] slave_address,
   output logic       busy,
   output tx_out_type tx_out
);

   logic                busy_ff, busy_in;
   logic [TX_IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]         crc_ff, crc_in;
   logic [TX_IDX_W-1:0] idx_cur;
   logic [7:0]          byte_cur;

   assign idx_cur = start ? TX_IDX_ADDR : idx_ff;

   always_comb begin
      case (idx_cur)
         TX_IDX_ADDR:     byte_cur = slave_address;
         TX_IDX_FUNC:     byte_cur = FUNC_READ_HOLD;
         TX_IDX_COUNT_LO: byte_cur = REG_COUNT_LO;
         TX_IDX_CRC_LO:   byte_cur = crc_ff[7:0];
         TX_IDX_CRC_HI:   byte_cur = crc_ff[15:8];
         default:         byte_cur = ZERO_BYTE;
      endcase
   end

   always_comb begin
      tx_out.emit    = start || (busy_ff && out_free);
      tx_out.tx_byte = byte_cur;
      tx_out.last    = (idx_cur == TX_IDX_CRC_HI);
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = TX_IDX_FUNC;
         crc_in  = crc_of_addr(slave_address);
      end else if (busy_ff && out_free) begin
         idx_in = idx_ff + TX_IDX_W'(1);
         if (idx_ff == TX_IDX_CRC_HI) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= TX_IDX_ADDR;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      crc_ff <= crc_in;
   end

   assign busy = busy_ff;

endmodule

// File: rtl/core/mwqf_rx.sv
// ----------------------------------------------------------------------------
// mwqf_rx
// Response byte counter and big-endian weight assembly
// ----------------------------------------------------------------------------
module mwqf_rx
   import mwqf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_beat_type req_beat,
   output rx_out_type   rx_out
);

   logic [3:0]  count_ff, count_in;
   logic [31:0] shift_ff, shift_in;
   logic [3:0]  count_nxt;
   logic [31:0] shift_nxt;

   always_comb begin
      shift_nxt = shift_ff;
      if (count_ff >= WEIGHT_FIRST && count_ff <= WEIGHT_LAST) begin
         shift_nxt = {shift_ff[23:0], req_beat.rx_byte};
      end
      count_nxt = (count_ff < RX_SAT) ? count_ff + 4'd1 : count_ff;
   end

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      rx_out.emit   = 1'b0;
      rx_out.weight = WEIGHT_ERROR;
      rx_out.error  = 1'b1;
      if (count_nxt == FRAME_LEN) begin
         rx_out.weight = shift_nxt;
         rx_out.error  = 1'b0;
      end
      if (accept) begin
         if (req_beat.kind == KIND_REQUEST) begin
            count_in = '0;
            shift_in = '0;
         end else if (req_beat.frame_end) begin
            rx_out.emit = 1'b1;
            count_in    = '0;
            shift_in    = '0;
         end else begin
            count_in = count_nxt;
            shift_in = shift_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         shift_ff <= '0;
      end else begin
         count_ff <= count_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// File: rtl/core/modbus_weight_query_framer.sv
// ----------------------------------------------------------------------------
// modbus_weight_query_framer
// Master side weight query: request frame with crc, response weight capture
// ----------------------------------------------------------------------------
// an accepted beat's first result beat is registered and shows in the cycle after the accept
// a request beat gives eight result beats, one per cycle while the output is not stalled;
// the next beat is taken once the eighth is loaded
// back-to-back response bytes are taken while the output is not stalled
// synchronous reset clears the sequencer, counters and output valid;
// slave address resets to 1
module modbus_weight_query_framer
   import mwqf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [7:0]   csr_write_data
);

   logic [7:0]   slave_address_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_ff, rsp_in;
   logic         out_free, accept, start, tx_busy;
   tx_out_type   tx_out;
   rx_out_type   rx_out;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = tx_busy || !out_free;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_data.kind == KIND_REQUEST);

   mwqf_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .out_free      (out_free),
      .slave_address (slave_address_ff),
      .busy          (tx_busy),
      .tx_out        (tx_out)
   );

   mwqf_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_beat (req_data),
      .rx_out   (rx_out)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (tx_out.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = RESULT_TX;
         rsp_in.tx_byte     = tx_out.tx_byte;
         rsp_in.last        = tx_out.last;
         rsp_in.weight      = '0;
         rsp_in.error       = 1'b0;
      end else if (rx_out.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_kind = RESULT_WEIGHT;
         rsp_in.tx_byte     = ZERO_BYTE;
         rsp_in.last        = 1'b1;
         rsp_in.weight      = rx_out.weight;
         rsp_in.error       = rx_out.error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         slave_address_ff <= 8'h01;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            slave_address_ff <= csr_write_data;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the modbus weight query framer: request frames with crc and
// weight capture from response bytes, checked beat by beat against a
// behavioural predictor under random idling and back-pressure
// ----------------------------------------------------------------------------
module tb;
   import mwqf_pkg::*;

   localparam int MAX_GAP       = 18;
   localparam int LONG_HOLD     = 150;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LIMIT  = 10;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   req_beat_type req_data         = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   rsp_beat_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data   = '0;

   modbus_weight_query_framer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   req_beat_type beat_q[$];
   rsp_beat_type expected_q[$];
   int           beats_queued  = 0;
   int           beats_taken   = 0;
   bit           req_taken     = 1'b0;

   // predictor state
   logic [7:0]   scale_addr    = 8'd1;
   logic [3:0]   rx_len        = '0;
   logic [31:0]  weight_acc    = '0;

   bit           gaps_on       = 1'b1;
   bit           long_hold_go  = 1'b0;
   bit           long_hold_done = 1'b0;
   int           send_gap      = 0;
   int           rsp_gap       = 0;

   int           mismatches    = 0;
   int           frames_sent   = 0;
   int           readings      = 0;
   int           flagged       = 0;
   int           addr_settings = 1;

   function automatic void predict_beat(input req_beat_type b);
      logic [7:0]   frame [8];
      logic [15:0]  crc;
      rsp_beat_type r;
      r = '0;
      if (b.kind == KIND_REQUEST) begin
         frame[0] = scale_addr;
         frame[1] = FUNC_READ_HOLD;
         frame[2] = ZERO_BYTE;
         frame[3] = ZERO_BYTE;
         frame[4] = ZERO_BYTE;
         frame[5] = REG_COUNT_LO;
         crc = CRC_INIT;
         for (int i = 0; i < 6; i++) begin
            crc = crc ^ {8'h00, frame[i]};
            for (int j = 0; j < 8; j++) begin
               crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFL) : (crc >> 1);
            end
         end
         frame[6] = crc[7:0];
         frame[7] = crc[15:8];
         for (int i = 0; i < 8; i++) begin
            r.result_kind = RESULT_TX;
            r.tx_byte     = frame[i];
            r.last        = (i == 7);
            expected_q    = {expected_q, r};
         end
         rx_len     = '0;
         weight_acc = '0;
         frames_sent++;
      end else begin
         if (rx_len >= WEIGHT_FIRST && rx_len <= WEIGHT_LAST) begin
            weight_acc = {weight_acc[23:0], b.rx_byte};
         end
         if (rx_len < RX_SAT) begin
            rx_len = rx_len + 4'd1;
         end
         if (b.frame_end) begin
            r.result_kind = RESULT_WEIGHT;
            r.last        = 1'b1;
            if (rx_len == FRAME_LEN) begin
               r.weight = weight_acc;
               r.error  = 1'b0;
            end else begin
               r.weight = WEIGHT_ERROR;
               r.error  = 1'b1;
               flagged++;
            end
            expected_q = {expected_q, r};
            readings++;
            rx_len     = '0;
            weight_acc = '0;
         end
      end
   endfunction

   // acceptance, prediction and result checking on the rising edge
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         scale_addr = 8'd1;
         rx_len     = '0;
         weight_acc = '0;
         req_taken  = 1'b0;
      end else begin
         if (csr_write_enable) begin
            scale_addr = csr_write_data;
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            predict_beat(req_data);
            beats_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected result beat: kind %0d tx %02h last %0d weight %0d err %0d",
                           rsp_data.result_kind, rsp_data.tx_byte, rsp_data.last,
                           rsp_data.weight, rsp_data.error);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.result_kind !== want.result_kind ||
                   rsp_data.tx_byte !== want.tx_byte || rsp_data.last !== want.last ||
                   rsp_data.weight !== want.weight || rsp_data.error !== want.error) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("mismatch: expected kind %0d tx %02h last %0d weight %0d err %0d",
                              want.result_kind, want.tx_byte, want.last, want.weight,
                              want.error);
                     $display("          got      kind %0d tx %02h last %0d weight %0d err %0d",
                              rsp_data.result_kind, rsp_data.tx_byte, rsp_data.last,
                              rsp_data.weight, rsp_data.error);
                  end
               end
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled beat stays put
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (beat_q.size() != 0 && gaps_on && $urandom_range(0, 9) == 0) begin
         send_gap = $urandom_range(1, MAX_GAP) - 1;
         req_valid <= 1'b0;
      end else if (beat_q.size() != 0) begin
         req_data  <= beat_q.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_gap = LONG_HOLD;
         end else if (rsp_gap == 0 && gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(1, MAX_GAP);
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_beat(input logic kind, input logic [7:0] b, input logic fe);
      req_beat_type beat;
      beat.kind      = kind;
      beat.rx_byte   = b;
      beat.frame_end = fe;
      beat_q         = {beat_q, beat};
      beats_queued++;
   endtask

   task automatic queue_random_traffic(input int n);
      int         target;
      int         len;
      int         pick;
      bit         broken;
      logic [7:0] b;
      target = beats_queued + n;
      while (beats_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            queue_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
         end else begin
            if (pick >= 25) begin
               queue_beat(KIND_REQUEST, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               len = FRAME_LEN;
            end else if (pick < 82) begin
               len = $urandom_range(1, FRAME_LEN - 1);
            end else begin
               len = $urandom_range(FRAME_LEN + 1, 14);
            end
            broken = ($urandom_range(0, 99) < 8);
            for (int k = 0; k < len; k++) begin
               b = 8'($urandom_range(0, 255));
               // all-zero or all-one bytes push weight bytes to their extremes
               if ($urandom_range(0, 4) == 0) begin
                  b = {8{b[0]}};
               end
               queue_beat(KIND_RX_BYTE, b, (k == len - 1) && !broken);
            end
         end
      end
   endtask

   task automatic write_slave_address(input logic [7:0] a);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= a;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      addr_settings++;
   endtask

   task automatic wait_quiet();
      while (beats_taken != beats_queued || expected_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [7:0] heavy [9];
      logic [7:0] light [9];
      logic [7:0] addr;
      heavy = '{8'h01, FUNC_READ_HOLD, 8'h04, 8'h80, 8'h00, 8'h00, 8'h00, 8'h5a, 8'ha5};
      light = '{8'hff, FUNC_READ_HOLD, 8'h04, 8'h7f, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats at the reset address
      @(posedge clock);
      queue_beat(KIND_REQUEST, 8'hff, 1'b1);
      for (int k = 0; k < 9; k++) begin
         queue_beat(KIND_RX_BYTE, heavy[k], k == 8);
      end
      queue_beat(KIND_RX_BYTE, 8'hff, 1'b1);
      queue_beat(KIND_RX_BYTE, 8'h12, 1'b0);
      queue_beat(KIND_RX_BYTE, 8'h34, 1'b0);
      queue_beat(KIND_REQUEST, 8'h00, 1'b0);
      for (int k = 0; k < 9; k++) begin
         queue_beat(KIND_RX_BYTE, light[k], k == 8);
      end
      wait_quiet();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: addr = 8'h00;
            1: addr = 8'hff;
            default: addr = 8'($urandom_range(0, 255));
         endcase
         write_slave_address(addr);
         gaps_on = (p != 6);
         @(posedge clock);
         if (p == 1) begin
            long_hold_go = 1'b1;
         end
         case (p)
            0: queue_random_traffic(40);
            1: queue_random_traffic(50);
            6: queue_random_traffic(75);
            default: queue_random_traffic(60);
         endcase
         wait_quiet();
      end

      $display("covered %0d request frames and %0d weight readings (%0d flagged bad)",
               frames_sent, readings, flagged);
      $display("over %0d slave address settings, %0d beats, %0d mismatches",
               addr_settings, beats_taken, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("modbus_weight_query_framer regression: pass");
      end else begin
         $display("modbus_weight_query_framer regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d result beats outstanding", expected_q.size());
      $display("modbus_weight_query_framer regression: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/mwqf_pkg.sv
rtl/core/mwqf_tx.sv
rtl/core/mwqf_rx.sv
rtl/core/modbus_weight_query_framer.sv
test/tb.sv
